>>> design/wsp_pkg.sv
// Shared types, constants and helpers for the warp starfield projector.
// No dependencies; used by the top level.
package wsp_pkg;

  localparam int unsigned POS_W    = 18;
  localparam int unsigned DEPTH_W  = 17;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned NUM_W    = 27;
  localparam int unsigned DEN_W    = 18;
  localparam int unsigned QUO_W    = 17;

  localparam logic [17:0] STEP_Q8 = 18'd1536;
  localparam logic [17:0] ONE_Q8  = 18'd256;

  localparam logic [7:0] RG_BASE  = 8'd160;
  localparam logic [6:0] RG_SPAN  = 7'd96;
  localparam logic [7:0] B_BASE   = 8'd200;
  localparam logic [5:0] B_SPAN   = 6'd56;

  typedef enum logic [0:0] {
    CFG_PANEL_WIDTH  = 1'b0,
    CFG_PANEL_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    CMD_PLACE   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic [DEPTH_W-1:0]        depth;
    logic [COLOUR_W-1:0]       colour;
  } star_t;

  function automatic logic [7:0] rg_tint(input logic [6:0] r);
    logic [6:0] m;
    begin
      m = (r >= RG_SPAN) ? r - RG_SPAN : r;
      return RG_BASE + {1'b0, m};
    end
  endfunction

  function automatic logic [7:0] b_tint(input logic [5:0] r);
    logic [5:0] m;
    begin
      m = (r >= B_SPAN) ? r - B_SPAN : r;
      return B_BASE + {2'b00, m};
    end
  endfunction

  function automatic logic [15:0] sat16(input logic signed [QUO_W:0] v);
    begin
      if (v > 18'sd32767) return 16'h7FFF;
      else if (v < -18'sd32768) return 16'h8000;
      else return v[15:0];
    end
  endfunction

endpackage

>>> design/warp_starfield_projector_top.sv
// Warp starfield projector: star table in one RAM, read-modify-write stage,
// projection and brightness through pipelined dividers. Uses wsp_pkg, wsp_ram, wsp_div.
//
//   channel  | handshake              | word
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid / in_stall    | cmd, star_index, rand_x/y/depth, rand_rgb
//   output   | out_valid / out_stall  | tail_x, tail_y, head_x, head_y, red, green, blue
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (ready always high)
//
// One word enters per cycle while in_stall is low. For an advance word, the
// accepting edge issues the RAM read, stage 1 updates the entry and registers
// the numerator operands, 17 divider stages follow (one quotient bit each),
// then the output register holds the result.
// Reset clears only valid bits and the panel registers; the star table is not
// cleared. A stalled output freezes the whole pipeline and raises in_stall.
module warp_starfield_projector_top #(
  parameter int unsigned STAR_COUNT    = 2048,
  parameter int unsigned MAX_PANEL_DIM = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [10:0] star_index,
  input  logic [15:0] rand_x,
  input  logic [15:0] rand_y,
  input  logic [15:0] rand_depth,
  input  logic [6:0]  rand_red,
  input  logic [6:0]  rand_green,
  input  logic [5:0]  rand_blue,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tail_x,
  output logic [15:0] tail_y,
  output logic [15:0] head_x,
  output logic [15:0] head_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
  localparam int unsigned DW = $bits(wsp_pkg::star_t);
  localparam int unsigned QW = wsp_pkg::QUO_W;

  // ---------------- configuration ----------------
  logic [8:0] panel_width;
  logic [8:0] panel_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= 9'd64;
      panel_height <= 9'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (wsp_pkg::cfg_index_t'(cfg_index))
        wsp_pkg::CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        wsp_pkg::CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp a raw panel dimension to 1 .. MAX_PANEL_DIM
  function automatic logic [8:0] eff_dim(input logic [8:0] v);
    begin
      if (v == 9'd0) return 9'd1;
      else if (v > 9'(MAX_PANEL_DIM)) return 9'(MAX_PANEL_DIM);
      else return v;
    end
  endfunction

  logic [8:0] w_eff;
  logic [8:0] h_eff;
  assign w_eff = eff_dim(panel_width);
  assign h_eff = eff_dim(panel_height);

  // the whole pipeline advances together unless a finished result is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic in_range;
  assign in_range = 32'(star_index) < 32'(STAR_COUNT);

  // ---------------- star table ----------------
  logic          ram_we;
  logic [AW-1:0] s1_addr;
  logic [DW-1:0] ram_rdata;
  wsp_pkg::star_t nxt;

  wsp_ram #(
    .WIDTH (DW),
    .DEPTH (STAR_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (adv),
    .raddr (AW'(star_index)),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1: read data arrives, update entry ----------------
  logic        s1_valid;
  logic        s1_cmd;
  logic [15:0] s1_rx, s1_ry, s1_rd;
  logic [6:0]  s1_rr, s1_rg;
  logic [5:0]  s1_rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= cmd;
      s1_addr <= AW'(star_index);
      s1_rx   <= rand_x;
      s1_ry   <= rand_y;
      s1_rd   <= rand_depth;
      s1_rr   <= rand_red;
      s1_rg   <= rand_green;
      s1_rb   <= rand_blue;
    end
  end

  // forward the last write: the read for this word was issued in the same
  // cycle the previous word wrote back
  logic           fwd_valid;
  logic [AW-1:0]  fwd_addr;
  wsp_pkg::star_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr <= s1_addr;
      fwd_data <= nxt;
    end
  end

  wsp_pkg::star_t    cur;
  logic signed [25:0] prod_x, prod_y;
  logic [24:0]        prod_d;
  logic signed [17:0] z_t;
  logic               respawn;
  logic [16:0]        full;
  logic [23:0]        col_new;
  logic signed [17:0] x_new, y_new;
  logic               res_valid;
  logic [16:0]        z_c, pz_c;

  always_comb begin
    cur     = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : wsp_pkg::star_t'(ram_rdata);
    // (frac - 0.5) * 2 * dim in Q8: flip the top bit to center, then shift
    prod_x  = $signed(s1_rx ^ 16'h8000) * $signed({1'b0, w_eff});
    prod_y  = $signed(s1_ry ^ 16'h8000) * $signed({1'b0, h_eff});
    prod_d  = 25'(s1_rd) * 25'(w_eff);
    x_new   = prod_x[24:7];
    y_new   = prod_y[24:7];
    full    = {w_eff, 8'h00};
    col_new = {wsp_pkg::rg_tint(s1_rr), wsp_pkg::rg_tint(s1_rg), wsp_pkg::b_tint(s1_rb)};
    z_t     = $signed({1'b0, cur.depth}) - $signed(wsp_pkg::STEP_Q8);
    respawn = z_t <= $signed(wsp_pkg::ONE_Q8);

    nxt       = cur;
    res_valid = 1'b0;
    z_c       = z_t[16:0];
    pz_c      = cur.depth;
    if (wsp_pkg::cmd_t'(s1_cmd) == wsp_pkg::CMD_PLACE) begin
      nxt.x      = x_new;
      nxt.y      = y_new;
      nxt.depth  = prod_d[24:8];
      nxt.colour = col_new;
    end else begin
      res_valid = 1'b1;
      if (respawn) begin
        nxt.x      = x_new;
        nxt.y      = y_new;
        nxt.depth  = full;
        nxt.colour = col_new;
        z_c        = full;
        pz_c       = full + wsp_pkg::STEP_Q8[16:0];
      end else begin
        nxt.depth  = z_t[16:0];
      end
    end
  end

  assign ram_we = s1_valid && adv;

  // ---------------- stage 2: numerators ----------------
  logic               s2_valid;
  logic [16:0]        s2_z, s2_pz;
  logic signed [17:0] s2_x, s2_y;
  logic [23:0]        s2_col;
  logic [8:0]         s2_w, s2_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_z   <= z_c;
      s2_pz  <= pz_c;
      s2_x   <= nxt.x;
      s2_y   <= nxt.y;
      s2_col <= nxt.colour;
      s2_w   <= w_eff;
      s2_h   <= h_eff;
    end
  end

  // dim*z + 200*coord, over 2*z gives centre + 100*coord/z
  function automatic logic signed [26:0] proj_num(input logic [8:0] dim,
                                                  input logic [16:0] zz,
                                                  input logic signed [17:0] c);
    logic [25:0] dz;
    begin
      dz = 26'(dim) * 26'(zz);
      return $signed({1'b0, dz}) + 27'(c) * 27'sd200;
    end
  endfunction

  logic signed [26:0] n_tx, n_ty, n_hx, n_hy, n_r, n_g, n_b;
  logic [16:0]        full2, diff;
  logic [24:0]        p_r, p_g, p_b;

  always_comb begin
    n_tx  = proj_num(s2_w, s2_pz, s2_x);
    n_ty  = proj_num(s2_h, s2_pz, s2_y);
    n_hx  = proj_num(s2_w, s2_z, s2_x);
    n_hy  = proj_num(s2_h, s2_z, s2_y);
    full2 = {s2_w, 8'h00};
    diff  = (s2_z < full2) ? full2 - s2_z : '0;
    p_r   = 25'(s2_col[23:16]) * 25'(diff);
    p_g   = 25'(s2_col[15:8]) * 25'(diff);
    p_b   = 25'(s2_col[7:0]) * 25'(diff);
    n_r   = $signed({2'b00, p_r});
    n_g   = $signed({2'b00, p_g});
    n_b   = $signed({2'b00, p_b});
  end

  // ---------------- dividers ----------------
  logic signed [QW:0] q_tx, q_ty, q_hx, q_hy, q_r, q_g, q_b;

  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_tx (
    .clk(clk), .en(adv), .num(n_tx), .den({s2_pz, 1'b0}), .quo(q_tx));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_ty (
    .clk(clk), .en(adv), .num(n_ty), .den({s2_pz, 1'b0}), .quo(q_ty));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_hx (
    .clk(clk), .en(adv), .num(n_hx), .den({s2_z, 1'b0}), .quo(q_hx));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_hy (
    .clk(clk), .en(adv), .num(n_hy), .den({s2_z, 1'b0}), .quo(q_hy));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_r (
    .clk(clk), .en(adv), .num(n_r), .den({1'b0, full2}), .quo(q_r));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_g (
    .clk(clk), .en(adv), .num(n_g), .den({1'b0, full2}), .quo(q_g));
  wsp_div #(.NUM_W(27), .DEN_W(18), .Q_W(QW)) u_div_b (
    .clk(clk), .en(adv), .num(n_b), .den({1'b0, full2}), .quo(q_b));

  // valid bits riding alongside the divider stages
  logic [QW-1:0] dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (adv) begin
      dv <= {dv[QW-2:0], s2_valid};
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_x <= wsp_pkg::sat16(q_tx);
      tail_y <= wsp_pkg::sat16(q_ty);
      head_x <= wsp_pkg::sat16(q_hx);
      head_y <= wsp_pkg::sat16(q_hy);
      red    <= q_r[7:0];
      green  <= q_g[7:0];
      blue   <= q_b[7:0];
    end
  end

endmodule

>>> design/wsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old word. No dependencies.
module wsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> design/wsp_div.sv
// Pipelined restoring floor divider: signed numerator, unsigned divisor,
// one quotient bit per stage. No dependencies.
module wsp_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned Q_W   = 17
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [Q_W:0]     quo
);

  logic [NUM_W-1:0] mag;
  logic             neg_in;

  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic             neg_r [Q_W];

  assign neg_in = num[NUM_W-1];
  assign mag    = neg_in ? NUM_W'(-num) : NUM_W'(num);

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [Q_W-1:0]   low_i;
    logic [Q_W-1:0]   q_i;
    logic [DEN_W-1:0] den_i;
    logic             neg_i;
    logic [DEN_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_i = DEN_W'(mag >> Q_W);
      assign low_i = mag[Q_W-1:0];
      assign q_i   = '0;
      assign den_i = den;
      assign neg_i = neg_in;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
      assign den_i = den_r[k-1];
      assign neg_i = neg_r[k-1];
    end

    assign trial = {rem_i, low_i[Q_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_i}) begin
          rem_r[k] <= DEN_W'(trial - {1'b0, den_i});
          q_r[k]   <= {q_i[Q_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[DEN_W-1:0];
          q_r[k]   <= {q_i[Q_W-2:0], 1'b0};
        end
        low_r[k] <= {low_i[Q_W-2:0], 1'b0};
        den_r[k] <= den_i;
        neg_r[k] <= neg_i;
      end
    end
  end

  // floor for negative numerators: -(q + (rem != 0))
  always_comb begin
    if (neg_r[Q_W-1]) begin
      quo = -$signed({1'b0, q_r[Q_W-1]}) - ((|rem_r[Q_W-1]) ? (Q_W+1)'(1) : '0);
    end else begin
      quo = $signed({1'b0, q_r[Q_W-1]});
    end
  end

endmodule

>>> design/wsp_check.sv
// Port-level checker for the warp starfield projector, bound to the top level.
// No package dependencies.
module wsp_check (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] tail_x,
  input logic [15:0] head_x,
  input logic [7:0]  red
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tail_x) && $stable(head_x) && $stable(red))
    else $error("held result word changed");

  // input is pushed back exactly while a result is held
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

  a_stall_when_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind warp_starfield_projector_top wsp_check u_wsp_check (.*);
